// File: hdl/pse_pkg.sv
// Package for the postfix stack evaluator: token and status codes, the
// request word handed to the arithmetic unit, and shared helpers.
// No dependencies.
package pse_pkg;

    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int ITER_W      = 5;
    localparam int DEPTH_DEF   = 16;
    localparam int OUT_TDATA_W = 40;

    // Token kinds carried on the input tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_REM  = 3'd5
    } cmd_t;

    // Expression status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    // Request to the shared arithmetic unit
    typedef struct packed {
        logic start;
        cmd_t op;
    } alu_req_t;

    // Keep the first error of an expression
    function automatic status_t flag_err(status_t cur, status_t code);
        return (cur == ST_OK) ? code : cur;
    endfunction

endpackage

// File: hdl/postfix_stack_evaluator.sv
// Postfix expression evaluator: token sequencer, operand stack RAM and
// shared arithmetic unit. Depends on pse_pkg, pse_ram and pse_alu.
//
// Usage: one token per input word. s_tuser is the token kind (push, add,
// subtract, multiply, divide, remainder), s_tdata the operand for a push,
// s_tlast marks the last token of an expression. After the last token one
// result word leaves on the m_ side: m_tdata holds the value popped from the
// stack top and the sticky status of the expression (ok, underflow, overflow,
// divide by zero); the stack and status then clear for the next expression.
// Timing: s_tready is high only while the sequencer is idle. A push, an
// ignored code or an operator that underflows is done in the idle state;
// other operators read both operands from the stack, then, unless a divide
// or remainder is by zero, run the shared arithmetic unit, which takes the
// 32 steps of the shared adder for multiply, divide and remainder. A token
// with s_tlast then has the stack top placed in the output register.
// The output register lets the next expression start while a result waits;
// if m_tready stays low, the sequencer holds at the end of the next
// expression until the register frees. Reset empties the stack, clears the
// status and drops any pending result; stack RAM contents need no clearing.
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = pse_pkg::DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pse_pkg::DATA_W-1:0]      s_tdata,   // [31:0] operand_value
    input  logic [pse_pkg::CMD_W-1:0]       s_tuser,   // [2:0] cmd
    input  logic                            s_tlast,   // end_of_expr
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pse_pkg::OUT_TDATA_W-1:0] m_tdata    // [31:0] result_value,
                                                       // [33:32] status
);
    import pse_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_RD_A     = 7'b0000010,
        S_RD_DATA  = 7'b0000100,
        S_ALU      = 7'b0001000,
        S_TOP      = 7'b0010000,
        S_TOP_WAIT = 7'b0100000,
        S_EMIT     = 7'b1000000
    } seq_state_t;

    seq_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    status_t             err_reg, err_next;
    cmd_t                op_reg, op_next;
    logic                end_reg, end_next;
    logic [DATA_W-1:0]   b_reg, b_next;
    logic [DATA_W-1:0]   res_reg, res_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]   m_value_reg, m_value_next;
    status_t             m_status_reg, m_status_next;

    logic                ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]   ram_wr_addr, ram_rd_addr;
    logic [DATA_W-1:0]   ram_wr_data, ram_rd_data;
    logic [CNT_W-1:0]    cnt_m1, cnt_m2;
    alu_req_t            alu_req;
    logic                alu_done;
    logic [DATA_W-1:0]   alu_result;
    logic                s_accept;

    assign cnt_m1   = count_reg - 1'b1;
    assign cnt_m2   = count_reg - 2'd2;
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-DATA_W-STATUS_W){1'b0}}, m_status_reg, m_value_reg};

    pse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    pse_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (ram_rd_data),
        .b       (b_reg),
        .done    (alu_done),
        .result  (alu_result)
    );

    // Token sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        err_next      = err_reg;
        op_next       = op_reg;
        end_next      = end_reg;
        b_next        = b_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = cnt_m2[ADDR_W-1:0];
        ram_wr_data   = alu_result;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = cnt_m1[ADDR_W-1:0];
        alu_req.start = 1'b0;
        alu_req.op    = op_reg;

        // drop the output word once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    op_next    = cmd_t'(s_tuser);
                    end_next   = s_tlast;
                    state_next = s_tlast ? S_TOP : S_IDLE;
                    case (s_tuser)
                        CMD_PUSH: begin
                            if (count_reg >= CNT_W'(STACK_DEPTH)) begin
                                err_next = flag_err(err_reg, ST_OVER);
                            end else begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = count_reg[ADDR_W-1:0];
                                ram_wr_data = s_tdata;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_REM: begin
                            if (count_reg < CNT_W'(2)) begin
                                err_next = flag_err(err_reg, ST_UNDER);
                            end else begin
                                // fetch the second operand from the top
                                ram_rd_en  = 1'b1;
                                state_next = S_RD_A;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_A: begin
                b_next      = ram_rd_data;
                ram_rd_en   = 1'b1;
                ram_rd_addr = cnt_m2[ADDR_W-1:0];
                state_next  = S_RD_DATA;
            end
            S_RD_DATA: begin
                if ((b_reg == '0) && (op_reg == CMD_DIV || op_reg == CMD_REM)) begin
                    // divide by zero: replace both operands with zero
                    err_next    = flag_err(err_reg, ST_DIVZ);
                    ram_wr_en   = 1'b1;
                    ram_wr_data = '0;
                    count_next  = cnt_m1;
                    state_next  = end_reg ? S_TOP : S_IDLE;
                end else begin
                    alu_req.start = 1'b1;
                    state_next    = S_ALU;
                end
            end
            S_ALU: begin
                if (alu_done) begin
                    ram_wr_en  = 1'b1;
                    count_next = cnt_m1;
                    state_next = end_reg ? S_TOP : S_IDLE;
                end
            end
            S_TOP: begin
                if (count_reg == '0) begin
                    err_next   = flag_err(err_reg, ST_UNDER);
                    res_next   = '0;
                    state_next = S_EMIT;
                end else begin
                    ram_rd_en  = 1'b1;
                    state_next = S_TOP_WAIT;
                end
            end
            S_TOP_WAIT: begin
                res_next   = ram_rd_data;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_value_next  = res_reg;
                    m_status_next = err_reg;
                    count_next    = '0;
                    err_next      = ST_OK;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            err_reg      <= ST_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            err_reg      <= err_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        end_reg      <= end_next;
        b_reg        <= b_next;
        res_reg      <= res_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

`ifndef SYNTHESIS
    // Stack never grows past its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // An operator only runs with both operands still counted on the stack
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ALU) |-> (count_reg >= CNT_W'(2)))
        else $error("arithmetic step without two operands");

    // A new result word leaves the stack and status cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> (count_reg == '0) && (err_reg == ST_OK))
        else $error("stack not cleared after result");

    // Input is taken only while the arithmetic unit is idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !alu_done)
        else $error("input ready while arithmetic unit busy");
`endif

endmodule

// File: hdl/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/pse_alu.sv
// Shared arithmetic unit: one 33-bit adder/subtractor used once for add and
// subtract, and 32 times then once more as a fix-up for shift-add multiply
// and restoring divide. Depends on pse_pkg.
module pse_alu (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  pse_pkg::alu_req_t        req,
    input  logic [pse_pkg::DATA_W-1:0] a,
    input  logic [pse_pkg::DATA_W-1:0] b,
    output logic                     done,
    output logic [pse_pkg::DATA_W-1:0] result
);
    import pse_pkg::*;

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_RUN  = 3'b010,
        A_FIX  = 3'b100
    } alu_state_t;

    alu_state_t          state_reg, state_next;
    cmd_t                op_reg, op_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    logic [DATA_W-1:0]   opa_reg, opa_next;
    logic [DATA_W-1:0]   opb_reg, opb_next;
    logic                neg_q_reg, neg_q_next;
    logic                neg_r_reg, neg_r_next;

    logic [DATA_W:0]     add_x, add_y;
    logic                add_sub;
    logic [DATA_W+1:0]   add_sum;
    logic                is_div;
    logic [DATA_W-1:0]   abs_a, abs_b;

    // The one adder: x + y or x - y, carry out set when x >= y on subtract
    assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {(DATA_W+1){add_sub}}}
                     + {{(DATA_W+1){1'b0}}, add_sub};

    assign is_div = (op_reg == CMD_DIV) || (op_reg == CMD_REM);
    assign abs_a  = a[DATA_W-1] ? (~a + 1'b1) : a;
    assign abs_b  = b[DATA_W-1] ? (~b + 1'b1) : b;

    assign done   = (state_reg == A_FIX);
    assign result = add_sum[DATA_W-1:0];

    // Select adder operands for the current step
    always_comb begin
        add_x   = {1'b0, acc_reg};
        add_y   = {1'b0, opa_reg};
        add_sub = 1'b0;
        case (state_reg)
            A_RUN: begin
                if (is_div) begin
                    add_x   = {acc_reg, opb_reg[DATA_W-1]};
                    add_sub = 1'b1;
                end
            end
            A_FIX: begin
                case (op_reg)
                    CMD_SUB: add_sub = 1'b1;
                    CMD_MUL: add_y = '0;
                    CMD_DIV: begin
                        add_x   = neg_q_reg ? '0 : {1'b0, opb_reg};
                        add_y   = neg_q_reg ? {1'b0, opb_reg} : '0;
                        add_sub = neg_q_reg;
                    end
                    CMD_REM: begin
                        add_x   = neg_r_reg ? '0 : {1'b0, acc_reg};
                        add_y   = neg_r_reg ? {1'b0, acc_reg} : '0;
                        add_sub = neg_r_reg;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Sequence load, iterate and final fix-up
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        iter_next  = iter_reg;
        acc_next   = acc_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    op_next    = req.op;
                    iter_next  = '0;
                    neg_q_next = a[DATA_W-1] ^ b[DATA_W-1];
                    neg_r_next = a[DATA_W-1];
                    case (req.op)
                        CMD_MUL: begin
                            acc_next   = '0;
                            opa_next   = a;
                            opb_next   = b;
                            state_next = A_RUN;
                        end
                        CMD_DIV, CMD_REM: begin
                            acc_next   = '0;
                            opa_next   = abs_b;
                            opb_next   = abs_a;
                            state_next = A_RUN;
                        end
                        default: begin
                            acc_next   = a;
                            opa_next   = b;
                            state_next = A_FIX;
                        end
                    endcase
                end
            end
            A_RUN: begin
                if (is_div) begin
                    // restoring step: keep the difference when no borrow
                    acc_next = add_sum[DATA_W+1] ? add_sum[DATA_W-1:0]
                                                 : add_x[DATA_W-1:0];
                    opb_next = {opb_reg[DATA_W-2:0], add_sum[DATA_W+1]};
                end else begin
                    if (opb_reg[0]) begin
                        acc_next = add_sum[DATA_W-1:0];
                    end
                    opa_next = {opa_reg[DATA_W-2:0], 1'b0};
                    opb_next = {1'b0, opb_reg[DATA_W-1:1]};
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == {ITER_W{1'b1}}) begin
                    state_next = A_FIX;
                end
            end
            A_FIX: begin
                state_next = A_IDLE;
            end
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        iter_reg  <= iter_next;
        acc_reg   <= acc_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

endmodule

// File: dv/postfix_stack_evaluator_tb.sv
// Self-checking testbench for postfix_stack_evaluator: directed token table, then random
// expressions; result words checked against typed rows or a built-in stack evaluator.
// Depends on pse_pkg and the postfix_stack_evaluator RTL.
module postfix_stack_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pse_pkg::*;

    localparam int STACK_DEPTH    = DEPTH_DEF;
    localparam int SADDR_W        = $clog2(STACK_DEPTH);
    localparam int RAND_ITEMS     = 1350;
    localparam int DIR_ROWS       = 25;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 200;
    localparam int DRAIN_EVERY    = 60;

    // Token codes the block ignores
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    localparam logic [DATA_W-1:0] INT_MAX_V = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] INT_MIN_V = 32'h8000_0000;
    localparam logic [DATA_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] val;
        logic              last;
    } token_t;

    typedef struct {
        logic [DATA_W-1:0] value;
        status_t           status;
    } eval_result_t;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] val;
        logic              last;
        bit                typed;
        logic [DATA_W-1:0] exp_value;
        status_t           exp_status;
    } dir_row_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata  = '0;
    logic [CMD_W-1:0]       s_tuser  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Evaluator state mirrored by the testbench
    logic [DATA_W-1:0] opnd_stk [STACK_DEPTH];
    int unsigned       stk_cnt     = 0;
    status_t           expr_status = ST_OK;

    eval_result_t expected_results [$];
    token_t       expr_tokens [$];
    int           mismatch_cnt = 0;
    int           burst_left   = 0;
    int           stall_cycles = 0;

    // Directed tokens; rows with typed set carry their result word
    dir_row_t dir_rows [DIR_ROWS] = '{
        // end mark on an empty stack, carried by an ignored code
        '{CMD_SPARE6, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, ST_UNDER},
        // add wraps past the largest value
        '{CMD_PUSH,   INT_MAX_V,     1'b0, 1'b0, 32'h0,         ST_OK},
        '{CMD_PUSH,   32'h0000_0001, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{CMD_ADD,    32'h0000_0000, 1'b1, 1'b1, INT_MIN_V,     ST_OK},
        // most negative value divided by minus one
        '{CMD_PUSH,   INT_MIN_V,     1'b0, 1'b0, 32'h0,         ST_OK},
        '{CMD_PUSH,   MINUS_ONE,     1'b0, 1'b0, 32'h0,         ST_OK},
        '{CMD_DIV,    32'hFFFF_FFFF, 1'b1, 1'b1, INT_MIN_V,     ST_OK},
        '{CMD_PUSH,   INT_MIN_V,     1'b0, 1'b0, 32'h0,         ST_OK},
        '{CMD_PUSH,   MINUS_ONE,     1'b0, 1'b0, 32'h0,         ST_OK},
        '{CMD_REM,    32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, ST_OK},
        // divide by zero pushes zero and the status sticks
        '{CMD_PUSH,   32'h0000_0007, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{CMD_PUSH,   32'h0000_0000, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{CMD_DIV,    32'h0000_0000, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{CMD_PUSH,   32'h0000_0005, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{CMD_ADD,    32'h0000_0000, 1'b1, 1'b1, 32'h0000_0005, ST_DIVZ},
        // operator on an empty stack, then end on an empty stack
        '{CMD_ADD,    32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, ST_UNDER},
        // signed remainder, multiply and subtract
        '{CMD_PUSH,   32'hFFFF_FFF9, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{CMD_PUSH,   32'h0000_0002, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{CMD_REM,    32'h0000_0000, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{CMD_PUSH,   32'h0000_0003, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{CMD_MUL,    32'h0000_0000, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{CMD_PUSH,   MINUS_ONE,     1'b0, 1'b0, 32'h0,         ST_OK},
        '{CMD_SUB,    32'h0000_0000, 1'b1, 1'b0, 32'h0,         ST_OK},
        // ignored code still honors the end mark
        '{CMD_PUSH,   32'h0000_0009, 1'b0, 1'b0, 32'h0,         ST_OK},
        '{CMD_SPARE7, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0009, ST_OK}
    };

    postfix_stack_evaluator #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] operand_value
        .s_tuser  (s_tuser),   // [2:0] cmd
        .s_tlast  (s_tlast),   // end_of_expr
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [31:0] result_value, [33:32] status
    );

    // 20 ns clock
    always begin
        #10ns aclk = 1'b1;
        #10ns aclk = 1'b0;
    end

    // Keep only the first fault of an expression
    function automatic void record_fault(input status_t code);
        if (expr_status == ST_OK) expr_status = code;
    endfunction

    // Apply one token to the mirrored stack; report the result word it causes
    function automatic void eval_token(input logic [CMD_W-1:0] cmd,
                                       input logic [DATA_W-1:0] val,
                                       input logic last,
                                       output bit has_res,
                                       output eval_result_t res);
        logic [DATA_W-1:0] lhs, rhs, r;
        longint            sl, sr, q;
        has_res    = 1'b0;
        res.value  = '0;
        res.status = ST_OK;
        r          = '0;
        if (cmd == CMD_PUSH) begin
            if (stk_cnt >= STACK_DEPTH) begin
                record_fault(ST_OVER);
            end else begin
                opnd_stk[SADDR_W'(stk_cnt)] = val;
                stk_cnt++;
            end
        end else if (cmd <= CMD_REM) begin
            if (stk_cnt < 2) begin
                record_fault(ST_UNDER);
            end else begin
                rhs = opnd_stk[SADDR_W'(stk_cnt-1)];
                lhs = opnd_stk[SADDR_W'(stk_cnt-2)];
                stk_cnt -= 2;
                sl = longint'($signed(lhs));
                sr = longint'($signed(rhs));
                case (cmd)
                    CMD_ADD: r = lhs + rhs;
                    CMD_SUB: r = lhs - rhs;
                    CMD_MUL: r = lhs * rhs;
                    default: begin
                        // 64-bit math keeps the most negative quotient wrap exact
                        if (rhs == '0) begin
                            record_fault(ST_DIVZ);
                            r = '0;
                        end else begin
                            q = (cmd == CMD_DIV) ? sl / sr : sl % sr;
                            r = q[DATA_W-1:0];
                        end
                    end
                endcase
                opnd_stk[SADDR_W'(stk_cnt)] = r;
                stk_cnt++;
            end
        end
        if (last) begin
            has_res = 1'b1;
            if (stk_cnt == 0) record_fault(ST_UNDER);
            else res.value = opnd_stk[SADDR_W'(stk_cnt-1)];
            res.status  = expr_status;
            stk_cnt     = 0;
            expr_status = ST_OK;
        end
    endfunction

    // Drive one token word in bursts; predict once it is taken
    task automatic send_token(input token_t tok, input bit typed,
                              input eval_result_t typed_res);
        bit           got;
        eval_result_t res;
        if (burst_left <= 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid = 1'b1;
        s_tdata  = tok.val;
        s_tuser  = tok.cmd;
        s_tlast  = tok.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        eval_token(tok.cmd, tok.val, tok.last, got, res);
        if (got) expected_results.push_back(typed ? typed_res : res);
        @(negedge aclk);
        burst_left--;
    endtask

    // Hold the sender until every pending result word has left
    task automatic hold_until_drained();
        s_tvalid = 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
    endtask

    // Mix of extremes, small values (zero divisors) and full-range values
    function automatic logic [DATA_W-1:0] rand_operand();
        logic [DATA_W-1:0] picks [5];
        picks = '{32'h0, 32'h1, MINUS_ONE, INT_MIN_V, INT_MAX_V};
        case ($urandom_range(0, 7))
            0:       return picks[3'($urandom_range(0, 4))];
            1, 2:    return DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
            default: return $urandom;
        endcase
    endfunction

    function automatic token_t make_token(input logic [CMD_W-1:0] cmd);
        token_t t;
        t.cmd  = cmd;
        t.val  = (cmd == CMD_PUSH) ? rand_operand() : $urandom;
        t.last = 1'b0;
        return t;
    endfunction

    // Build a valid postfix expression, with a little noise and leftovers
    task automatic build_well_formed();
        int     pushes_left, depth, push_bias;
        bit     leave_rest;
        token_t t;
        expr_tokens.delete();
        pushes_left = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 24)
                                                  : $urandom_range(1, 7);
        push_bias  = $urandom_range(1, 3);
        leave_rest = ($urandom_range(0, 7) == 0);
        depth      = 0;
        while (pushes_left > 0 || (depth > 1 && !leave_rest)) begin
            if ($urandom_range(0, 19) == 0)
                expr_tokens.push_back(make_token($urandom_range(0, 1) ? CMD_SPARE6
                                                                      : CMD_SPARE7));
            if (pushes_left > 0 && (depth < 2 ||
                (depth < STACK_DEPTH && $urandom_range(0, 3) < push_bias))) begin
                expr_tokens.push_back(make_token(CMD_PUSH));
                depth++;
                pushes_left--;
            end else begin
                expr_tokens.push_back(make_token(CMD_W'($urandom_range(CMD_ADD, CMD_REM))));
                depth--;
            end
        end
        // End mark either on the last token or on a trailing ignored one
        if ($urandom_range(0, 9) == 0) begin
            t      = make_token(CMD_SPARE7);
            t.last = 1'b1;
            expr_tokens.push_back(t);
        end else begin
            expr_tokens[expr_tokens.size()-1].last = 1'b1;
        end
    endtask

    // Build a broken expression: random tokens, or an overrun of the stack
    task automatic build_broken(input bit overrun);
        int n;
        expr_tokens.delete();
        if (overrun) begin
            repeat (STACK_DEPTH + $urandom_range(1, 4))
                expr_tokens.push_back(make_token(CMD_PUSH));
            repeat ($urandom_range(0, 3))
                expr_tokens.push_back(make_token(CMD_W'($urandom_range(1, 7))));
        end else begin
            n = $urandom_range(1, 20);
            repeat (n)
                expr_tokens.push_back(make_token($urandom_range(0, 1) ? CMD_PUSH
                                                 : CMD_W'($urandom_range(1, 7))));
        end
        expr_tokens[expr_tokens.size()-1].last = 1'b1;
    endtask

    // Stimulus
    initial begin
        eval_result_t no_typed;
        eval_result_t row_res;
        token_t       tok;
        int           counted, n_expr, kind;
        no_typed.value  = '0;
        no_typed.status = ST_OK;
        counted = 0;
        n_expr  = 0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // Directed table
        foreach (dir_rows[i]) begin
            tok.cmd           = dir_rows[i].cmd;
            tok.val           = dir_rows[i].val;
            tok.last          = dir_rows[i].last;
            row_res.value     = dir_rows[i].exp_value;
            row_res.status    = dir_rows[i].exp_status;
            send_token(tok, dir_rows[i].typed, row_res);
        end
        hold_until_drained();

        // Random expressions
        while (counted < RAND_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) build_well_formed();
            else build_broken(kind == 9 && $urandom_range(0, 1));
            foreach (expr_tokens[i]) begin
                send_token(expr_tokens[i], 1'b0, no_typed);
                counted++;
            end
            n_expr++;
            if (n_expr % DRAIN_EVERY == 0) hold_until_drained();
        end
        s_tvalid = 1'b0;

        // Drain and finish
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Receiver backpressure: modes of random length
    always @(negedge aclk) begin
        static int mode = 0;
        static int mode_left = 0;
        if (mode_left <= 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ~m_tready;
        endcase
    end

    // Check each result word against the oldest expectation
    always @(posedge aclk) begin
        eval_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result word with no expectation waiting: %h", m_tdata);
                mismatch_cnt++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[DATA_W-1:0] !== want.value) begin
                    $error("result_value mismatch: expected %h, actual %h",
                           want.value, m_tdata[DATA_W-1:0]);
                    mismatch_cnt++;
                end
                if (m_tdata[DATA_W+STATUS_W-1:DATA_W] !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, m_tdata[DATA_W+STATUS_W-1:DATA_W]);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
